[sv/vlb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlb_pkg
// Shared types, codes and helpers of the vertex link builder.
// ----------------------------------------------------------------------------
package vlb_pkg;

	// item codes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_CODE  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_VERTEX  = 2'd0;
	localparam logic [1:0] KIND_READOUT = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_HEIGHT = 1'b1;
	localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 9'd16;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 9'd16;

	// field widths
	localparam int IN_SITE_W  = 8;
	localparam int CODE_W     = 11;
	localparam int INDEX_W    = 16;
	localparam int TYPE_W     = 3;
	localparam int PART_W     = 18;
	localparam int NSITES_W   = 18;
	// site index width covering the largest supported site store
	localparam int SITE_IDX_W = 12;
	// working width of the bond decode arithmetic
	localparam int ARITH_W    = 19;
	// divider steps per cycle
	localparam int DIV_STEPS  = 4;

	// request from the front to the back
	typedef struct packed {
		logic [1:0]            op;
		logic                  site_ok;
		logic [SITE_IDX_W-1:0] site;
		logic                  spin_up;
		logic                  offdiag;
		logic                  bad;
		logic [SITE_IDX_W-1:0] s0;
		logic [SITE_IDX_W-1:0] s1;
	} cmd_t;

	// one result request
	typedef struct packed {
		logic [1:0]         kind;
		logic [INDEX_W-1:0] vertex_index;
		logic [TYPE_W-1:0]  vertex_type;
		logic               leg0_valid;
		logic [PART_W-1:0]  leg0_partner;
		logic               leg1_valid;
		logic [PART_W-1:0]  leg1_partner;
		logic               final_spin_up;
	} res_t;

	// vertex class from the spins under the operator
	function automatic logic [TYPE_W-1:0] classify(input logic offdiag, input logic u0,
			input logic u1);
		logic [TYPE_W-1:0] t;
		t = 3'd0;
		if (!offdiag) begin
			case ({u0, u1})
				2'b00:   t = 3'd1;
				2'b11:   t = 3'd2;
				2'b10:   t = 3'd3;
				default: t = 3'd4;
			endcase
		end else begin
			case ({u0, u1})
				2'b01:   t = 3'd5;
				2'b10:   t = 3'd6;
				default: t = 3'd0;
			endcase
		end
		return t;
	endfunction

endpackage

[sv/vlb_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlb_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module vlb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push_ok, pop_ok;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign push_ok  = push && !full;
	assign pop_ok   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push_ok) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop_ok)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push_ok && !pop_ok)      cnt_q <= cnt_q + 1'b1;
			else if (pop_ok && !push_ok) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[sv/vlb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlb_front
// Takes items, holds the lattice registers and decodes bonds to site pairs.
// ----------------------------------------------------------------------------
module vlb_front #(
	parameter int MAX_SITES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [1:0]                          in_op,
	input  logic [vlb_pkg::IN_SITE_W-1:0]       in_site,
	input  logic                                in_spin_up,
	input  logic [vlb_pkg::CODE_W-1:0]          in_code,
	output logic                                busy,
	input  logic                                wr_en,
	input  logic [vlb_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [vlb_pkg::CFG_DATA_W-1:0]      wr_data,
	output logic                                q_push,
	output vlb_pkg::cmd_t                       q_cmd,
	input  logic                                q_full
);

	localparam int SITE_W  = $clog2(MAX_SITES);
	localparam int DIV_CYC = (SITE_W + vlb_pkg::DIV_STEPS - 1) / vlb_pkg::DIV_STEPS;
	localparam int DVD_W   = DIV_CYC * vlb_pkg::DIV_STEPS;
	localparam int DCNT_W  = $clog2(DIV_CYC + 1);
	localparam int AW      = vlb_pkg::ARITH_W;

	logic [vlb_pkg::CFG_DATA_W-1:0] width_q, height_q;
	logic [vlb_pkg::NSITES_W-1:0]   nsites_q;

	logic                           v_s1;
	logic [1:0]                     op_s1;
	logic [vlb_pkg::IN_SITE_W-1:0]  site_s1;
	logic                           spin_s1;
	logic [vlb_pkg::CODE_W-1:0]     code_s1;

	logic [DVD_W-1:0]               dvd_q, dvd_v;
	logic [9:0]                     rem_q, rem_v;
	logic [DCNT_W-1:0]              div_left_q;

	logic [9:0]    in_k, k_s1, bond_s1;
	logic [AW-1:0] in_s_a, n_a, w_a, bond_a, lim_a, s_a, x_a, t_a, s0_a, s1_a;
	logic          chain, bad, is_code, is_ident, need_div, ready_s1, drop, fwd;

	// lattice registers; the site count is a registered product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= vlb_pkg::WIDTH_RST;
			height_q <= vlb_pkg::HEIGHT_RST;
			nsites_q <= 18'd256;
		end else begin
			if (wr_en && wr_index == vlb_pkg::CFG_LATTICE_WIDTH)  width_q  <= wr_data;
			if (wr_en && wr_index == vlb_pkg::CFG_LATTICE_HEIGHT) height_q <= wr_data;
			nsites_q <= width_q * height_q;
		end
	end

	// item holding stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid) begin
			v_s1 <= 1'b1;
		end else if (fwd) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			op_s1   <= in_op;
			site_s1 <= in_site;
			spin_s1 <= in_spin_up;
			code_s1 <= in_code;
		end
	end

	// site of the bond start, taken straight from the incoming code
	assign in_k   = in_code[10:1] - 10'd1;
	assign in_s_a = AW'(in_k[9:1]);

	// remainder divider, several restoring steps per cycle
	always_comb begin
		rem_v = rem_q;
		dvd_v = dvd_q;
		for (int i = 0; i < vlb_pkg::DIV_STEPS; i++) begin
			rem_v = {rem_v[8:0], dvd_v[DVD_W-1]};
			dvd_v = dvd_v << 1;
			if (rem_v >= {1'b0, width_q}) rem_v = rem_v - {1'b0, width_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_left_q <= '0;
		end else if (in_valid) begin
			div_left_q <= DCNT_W'(DIV_CYC);
		end else if (div_left_q != '0) begin
			div_left_q <= div_left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			dvd_q <= in_s_a[DVD_W-1:0];
			rem_q <= '0;
		end else if (div_left_q != '0) begin
			dvd_q <= dvd_v;
			rem_q <= rem_v;
		end
	end

	// bond check
	assign bond_s1 = code_s1[10:1];
	assign k_s1    = bond_s1 - 10'd1;
	assign chain   = height_q == 9'd1;
	assign n_a     = AW'(nsites_q);
	assign w_a     = AW'(width_q);
	assign bond_a  = AW'(bond_s1);
	assign lim_a   = chain ? n_a : (n_a << 1);
	assign bad     = (nsites_q == '0) || (n_a > AW'(MAX_SITES)) || (bond_s1 == '0)
		|| (bond_a > lim_a);

	// site pair of the bond
	assign s_a = AW'(k_s1[9:1]);
	assign x_a = AW'(rem_q);
	assign t_a = s_a + w_a;
	always_comb begin
		if (chain) begin
			s0_a = bond_a - 1'b1;
			s1_a = (bond_a == w_a) ? '0 : bond_a;
		end else begin
			s0_a = s_a;
			if (!k_s1[0]) s1_a = (x_a + 1'b1 == w_a) ? s_a - x_a : s_a + 1'b1;
			else          s1_a = (t_a >= n_a) ? t_a - n_a : t_a;
		end
	end

	// hand-off to the queue; identity codes are dropped here
	assign is_code  = op_s1 == vlb_pkg::OP_CODE;
	assign is_ident = code_s1 == '0;
	assign need_div = is_code && !is_ident && !bad && !chain;
	assign ready_s1 = !need_div || (div_left_q == '0);
	assign drop     = is_code && is_ident;
	assign fwd      = v_s1 && ready_s1 && (drop || !q_full);
	assign q_push   = v_s1 && ready_s1 && !drop && !q_full;
	assign busy     = v_s1 && !fwd;

	always_comb begin
		q_cmd         = '0;
		q_cmd.op      = op_s1;
		q_cmd.site_ok = AW'(site_s1) < AW'(MAX_SITES);
		q_cmd.site    = vlb_pkg::SITE_IDX_W'(site_s1);
		q_cmd.spin_up = spin_s1;
		q_cmd.offdiag = code_s1[0];
		q_cmd.bad     = bad;
		q_cmd.s0      = s0_a[vlb_pkg::SITE_IDX_W-1:0];
		q_cmd.s1      = s1_a[vlb_pkg::SITE_IDX_W-1:0];
	end

endmodule

[sv/vlb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlb_back
// Runs requests against the leg and spin memories and forms results.
// ----------------------------------------------------------------------------
module vlb_back #(
	parameter int MAX_SITES    = 256,
	parameter int MAX_VERTICES = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	output logic          q_pop,
	input  vlb_pkg::cmd_t q_cmd,
	input  logic          r_full,
	output logic          r_push,
	output vlb_pkg::res_t r_res,
	output logic          init_busy
);

	localparam int SITE_W = $clog2(MAX_SITES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int P_W    = $clog2(MAX_VERTICES);
	localparam int LEG_W  = P_W + 2;
	localparam int ENT_W  = LEG_W + 1;
	localparam int PW     = vlb_pkg::PART_W;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_IDLE  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_VA    = 3'd4;
	localparam logic [2:0] ST_VB    = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [SITE_W-1:0] sweep_q;
	logic [CNT_W-1:0]  cnt_q;
	vlb_pkg::cmd_t     cmd_q;

	// leg entries hold a valid bit above the leg number
	logic [ENT_W-1:0]  first_mem [MAX_SITES];
	logic [ENT_W-1:0]  last_mem [MAX_SITES];
	logic              spin_mem [MAX_SITES];

	logic              fw_en, lw_en, sw_en, rd_en;
	logic [SITE_W-1:0] fw_addr, lw_addr, sw_addr, ra0, ra1;
	logic [ENT_W-1:0]  fw_data, lw_data;
	logic              sw_data;
	logic [ENT_W-1:0]  first_rd_q, last_rd0_q, last_rd1_q;
	logic              spin_rd0_q, spin_rd1_q;

	logic                       cnt_clr, cnt_inc, sweep_clr, sweep_inc, cmd_load;
	logic                       overflow, same, lv1;
	logic [LEG_W-1:0]           base, part1;
	logic [SITE_W-1:0]          s0, s1, site;
	logic [CNT_W+15:0]          idx_wide;
	logic [vlb_pkg::INDEX_W-1:0] idx;

	// leg number to output width, zero when the entry is empty
	function automatic logic [PW-1:0] leg_out(input logic vld, input logic [LEG_W-1:0] leg);
		logic [LEG_W+PW-1:0] wide;
		wide = {{PW{1'b0}}, leg};
		return vld ? wide[PW-1:0] : '0;
	endfunction

	assign init_busy = state_q == ST_INIT;
	assign overflow  = cnt_q >= CNT_W'(MAX_VERTICES);
	assign idx_wide  = {16'd0, cnt_q};
	assign idx       = idx_wide[15:0];
	assign base      = {cnt_q[P_W-1:0], 2'b00};
	assign s0        = cmd_q.s0[SITE_W-1:0];
	assign s1        = cmd_q.s1[SITE_W-1:0];
	assign site      = cmd_q.site[SITE_W-1:0];
	assign same      = cmd_q.s0 == cmd_q.s1;
	assign lv1       = same || last_rd1_q[LEG_W];
	assign part1     = same ? (base | LEG_W'(3)) : last_rd1_q[LEG_W-1:0];

	// sequencer
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		r_push    = 1'b0;
		r_res     = '0;
		fw_en     = 1'b0;
		fw_addr   = sweep_q;
		fw_data   = '0;
		lw_en     = 1'b0;
		lw_addr   = sweep_q;
		lw_data   = '0;
		sw_en     = 1'b0;
		sw_addr   = sweep_q;
		sw_data   = 1'b0;
		rd_en     = 1'b0;
		ra0       = q_cmd.s0[SITE_W-1:0];
		ra1       = q_cmd.s1[SITE_W-1:0];
		cnt_clr   = 1'b0;
		cnt_inc   = 1'b0;
		sweep_clr = 1'b0;
		sweep_inc = 1'b0;
		cmd_load  = 1'b0;
		case (state_q)
			// clearing pass: legs always, spins only after reset
			ST_INIT, ST_CLEAR: begin
				fw_en     = 1'b1;
				lw_en     = 1'b1;
				sw_en     = state_q == ST_INIT;
				sweep_inc = 1'b1;
				if (sweep_q == SITE_W'(MAX_SITES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					case (q_cmd.op)
						vlb_pkg::OP_CLEAR: begin
							q_pop     = 1'b1;
							cnt_clr   = 1'b1;
							sweep_clr = 1'b1;
							state_d   = ST_CLEAR;
						end
						vlb_pkg::OP_LOAD: begin
							q_pop   = 1'b1;
							sw_en   = q_cmd.site_ok;
							sw_addr = q_cmd.site[SITE_W-1:0];
							sw_data = q_cmd.spin_up;
						end
						vlb_pkg::OP_READ: begin
							q_pop    = 1'b1;
							rd_en    = 1'b1;
							ra0      = q_cmd.site[SITE_W-1:0];
							cmd_load = 1'b1;
							state_d  = ST_READ;
						end
						default: begin
							if (q_cmd.bad || overflow) begin
								if (!r_full) begin
									q_pop              = 1'b1;
									r_push             = 1'b1;
									r_res.kind         = vlb_pkg::KIND_ERROR;
									r_res.vertex_index = idx;
								end
							end else begin
								q_pop    = 1'b1;
								rd_en    = 1'b1;
								cmd_load = 1'b1;
								state_d  = ST_VA;
							end
						end
					endcase
				end
			end
			ST_READ: begin
				if (!r_full) begin
					r_push              = 1'b1;
					r_res.kind          = vlb_pkg::KIND_READOUT;
					r_res.leg0_valid    = cmd_q.site_ok && first_rd_q[LEG_W];
					r_res.leg0_partner  = leg_out(r_res.leg0_valid, first_rd_q[LEG_W-1:0]);
					r_res.leg1_valid    = cmd_q.site_ok && last_rd0_q[LEG_W];
					r_res.leg1_partner  = leg_out(r_res.leg1_valid, last_rd0_q[LEG_W-1:0]);
					r_res.final_spin_up = cmd_q.site_ok && spin_rd0_q;
					state_d             = ST_IDLE;
				end
			end
			// first site: link leg 4p, leave leg 4p+3
			ST_VA: begin
				lw_en   = 1'b1;
				lw_addr = s0;
				lw_data = {1'b1, base | LEG_W'(3)};
				fw_en   = !last_rd0_q[LEG_W];
				fw_addr = s0;
				fw_data = {1'b1, base};
				sw_en   = cmd_q.offdiag && !same;
				sw_addr = s0;
				sw_data = !spin_rd0_q;
				state_d = ST_VB;
			end
			// second site: link leg 4p+1, leave leg 4p+2, send the vertex
			ST_VB: begin
				if (!r_full) begin
					lw_en              = 1'b1;
					lw_addr            = s1;
					lw_data            = {1'b1, base | LEG_W'(2)};
					fw_en              = !lv1;
					fw_addr            = s1;
					fw_data            = {1'b1, base | LEG_W'(1)};
					sw_en              = cmd_q.offdiag && !same;
					sw_addr            = s1;
					sw_data            = !spin_rd1_q;
					cnt_inc            = 1'b1;
					r_push             = 1'b1;
					r_res.kind         = vlb_pkg::KIND_VERTEX;
					r_res.vertex_index = idx;
					r_res.vertex_type  = vlb_pkg::classify(cmd_q.offdiag, spin_rd0_q,
						spin_rd1_q);
					r_res.leg0_valid   = last_rd0_q[LEG_W];
					r_res.leg0_partner = leg_out(last_rd0_q[LEG_W], last_rd0_q[LEG_W-1:0]);
					r_res.leg1_valid   = lv1;
					r_res.leg1_partner = leg_out(lv1, part1);
					state_d            = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (sweep_clr)      sweep_q <= '0;
			else if (sweep_inc) sweep_q <= sweep_q + 1'b1;
			if (cnt_clr)        cnt_q <= '0;
			else if (cnt_inc)   cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_load) cmd_q <= q_cmd;
	end

	// first-leg memory
	always_ff @(posedge clk) begin
		if (fw_en) first_mem[fw_addr] <= fw_data;
		if (rd_en) first_rd_q <= first_mem[ra0];
	end

	// last-leg memory
	always_ff @(posedge clk) begin
		if (lw_en) last_mem[lw_addr] <= lw_data;
		if (rd_en) begin
			last_rd0_q <= last_mem[ra0];
			last_rd1_q <= last_mem[ra1];
		end
	end

	// spin memory
	always_ff @(posedge clk) begin
		if (sw_en) spin_mem[sw_addr] <= sw_data;
		if (rd_en) begin
			spin_rd0_q <= spin_mem[ra0];
			spin_rd1_q <= spin_mem[ra1];
		end
	end

	// site is only read back through ra0 on a readout
	logic unused_site;
	assign unused_site = ^site;

endmodule

[sv/vertex_link_builder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_link_builder_unit
// Builds the linked vertex list of an operator string, one item at a time.
// On a square lattice an operator also waits in the front for the remainder
//   division by the width; a chain operator needs no division.
// An operator passes the back's idle, first-site and second-site states (two
//   writes per leg/spin memory port), a readout its idle and read states; a load
//   is written from idle; a clear sweeps the leg memories. Reset: lattice 16 x 16,
//   counter zero; full stays high while the leg and spin memories are swept clear.
// ----------------------------------------------------------------------------
module vertex_link_builder_unit #(
	parameter int MAX_SITES    = 256,
	parameter int MAX_VERTICES = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [1:0]                         op,
	input  logic [vlb_pkg::IN_SITE_W-1:0]      site,
	input  logic                               spin_up,
	input  logic [vlb_pkg::CODE_W-1:0]         operator_code,
	output logic                               empty,
	input  logic                               pop,
	output logic [1:0]                         kind,
	output logic [vlb_pkg::INDEX_W-1:0]        vertex_index,
	output logic [vlb_pkg::TYPE_W-1:0]         vertex_type,
	output logic                               leg0_valid,
	output logic [vlb_pkg::PART_W-1:0]         leg0_partner,
	output logic                               leg1_valid,
	output logic [vlb_pkg::PART_W-1:0]         leg1_partner,
	output logic                               final_spin_up,
	input  logic                               wr_en,
	input  logic [vlb_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [vlb_pkg::CFG_DATA_W-1:0]     wr_data
);

	localparam int CMD_W = $bits(vlb_pkg::cmd_t);
	localparam int RES_W = $bits(vlb_pkg::res_t);

	logic             front_busy, init_busy, accept;
	logic             cq_push, cq_full, cq_pop, cq_empty;
	vlb_pkg::cmd_t    cq_in, cq_out;
	logic [CMD_W-1:0] cq_out_bits;
	logic             rq_push, rq_full;
	vlb_pkg::res_t    rq_in, rq_out;
	logic [RES_W-1:0] rq_out_bits;

	assign full   = front_busy || init_busy;
	assign accept = push && !full;

	// front: decode
	vlb_front #(.MAX_SITES(MAX_SITES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.in_op      (op),
		.in_site    (site),
		.in_spin_up (spin_up),
		.in_code    (operator_code),
		.busy       (front_busy),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.q_push     (cq_push),
		.q_cmd      (cq_in),
		.q_full     (cq_full)
	);

	// request queue between front and back
	vlb_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cq_push),
		.push_data (cq_in),
		.full      (cq_full),
		.pop       (cq_pop),
		.pop_data  (cq_out_bits),
		.empty     (cq_empty)
	);
	assign cq_out = vlb_pkg::cmd_t'(cq_out_bits);

	// back: memories and results
	vlb_back #(.MAX_SITES(MAX_SITES), .MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (cq_empty),
		.q_pop     (cq_pop),
		.q_cmd     (cq_out),
		.r_full    (rq_full),
		.r_push    (rq_push),
		.r_res     (rq_in),
		.init_busy (init_busy)
	);

	// result queue
	vlb_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rq_push),
		.push_data (rq_in),
		.full      (rq_full),
		.pop       (pop),
		.pop_data  (rq_out_bits),
		.empty     (empty)
	);
	assign rq_out = vlb_pkg::res_t'(rq_out_bits);

	assign kind          = rq_out.kind;
	assign vertex_index  = rq_out.vertex_index;
	assign vertex_type   = rq_out.vertex_type;
	assign leg0_valid    = rq_out.leg0_valid;
	assign leg0_partner  = rq_out.leg0_partner;
	assign leg1_valid    = rq_out.leg1_valid;
	assign leg1_partner  = rq_out.leg1_partner;
	assign final_spin_up = rq_out.final_spin_up;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams clears, spin loads, operator codes and site reads into the vertex
// link builder. Both sides stall at random. A scoreboard tracks the leg
// stores, spins and vertex counter and checks every popped result in order.
// ----------------------------------------------------------------------------
module testbench;
	import vlb_pkg::*;

	localparam int MAX_SITES        = 256;
	localparam int MAX_VERTICES     = 65536;
	localparam int SETTLE_CYCLES    = 300;
	localparam int SHOWN_MISMATCHES = 10;
	localparam longint RUN_LIMIT_NS = 64'd40_000_000;

	// vertex classes: diagonal by spins under the operator, then off-diagonal
	localparam logic [TYPE_W-1:0] VT_IMPOSSIBLE = 3'd0;
	localparam logic [TYPE_W-1:0] VT_DIAG_DD    = 3'd1;
	localparam logic [TYPE_W-1:0] VT_DIAG_UU    = 3'd2;
	localparam logic [TYPE_W-1:0] VT_DIAG_UD    = 3'd3;
	localparam logic [TYPE_W-1:0] VT_DIAG_DU    = 3'd4;
	localparam logic [TYPE_W-1:0] VT_FLIP_DU    = 3'd5;
	localparam logic [TYPE_W-1:0] VT_FLIP_UD    = 3'd6;

	// tracks the block's stores and holds the results still to be popped
	class link_scoreboard;
		int unsigned lat_w;
		int unsigned lat_h;
		bit          spin_state [MAX_SITES];
		bit          first_ok [MAX_SITES];
		int unsigned first_leg [MAX_SITES];
		bit          last_ok [MAX_SITES];
		int unsigned last_leg [MAX_SITES];
		int unsigned vertex_count;
		res_t        pending_results [$];
		int unsigned mismatch_count;

		function new();
			lat_w = WIDTH_RST;
			lat_h = HEIGHT_RST;
			foreach (spin_state[i]) spin_state[i] = 1'b0;
			clear_legs();
			mismatch_count = 0;
		endfunction

		function void clear_legs();
			foreach (first_ok[i]) begin
				first_ok[i]  = 1'b0;
				first_leg[i] = 0;
				last_ok[i]   = 1'b0;
				last_leg[i]  = 0;
			end
			vertex_count = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == CFG_LATTICE_WIDTH) lat_w = value;
			else lat_h = value;
		endfunction

		// sites joined by a bond; 0 when the bond or the lattice is bad
		function bit bond_ends(int unsigned bond, output int unsigned s0,
				output int unsigned s1);
			int unsigned n, k, s, x, y;
			n  = lat_w * lat_h;
			s0 = 0;
			s1 = 0;
			if (n == 0 || n > MAX_SITES || bond == 0) return 1'b0;
			if (lat_h == 1) begin
				if (bond > n) return 1'b0;
				s0 = bond - 1;
				s1 = bond % lat_w;
			end else begin
				if (bond > 2 * n) return 1'b0;
				k  = bond - 1;
				s  = k >> 1;
				x  = s % lat_w;
				y  = s / lat_w;
				s0 = s;
				if (k[0] == 1'b0) s1 = y * lat_w + (x + 1) % lat_w;
				else s1 = ((y + 1) % lat_h) * lat_w + x;
			end
			return 1'b1;
		endfunction

		function logic [TYPE_W-1:0] vertex_class(bit offdiag, bit u0, bit u1);
			if (!offdiag) begin
				if (!u0 && !u1) return VT_DIAG_DD;
				if (u0 && u1) return VT_DIAG_UU;
				if (u0) return VT_DIAG_UD;
				return VT_DIAG_DU;
			end
			if (!u0 && u1) return VT_FLIP_DU;
			if (u0 && !u1) return VT_FLIP_UD;
			return VT_IMPOSSIBLE;
		endfunction

		// apply one accepted request and queue the result it causes
		function void note_request(logic [1:0] op_i, logic [IN_SITE_W-1:0] site_i,
				logic spin_i, logic [CODE_W-1:0] code_i);
			res_t        r;
			int unsigned ends [2];
			int unsigned st, leg;
			bit          offdiag;
			r = '0;
			case (op_i)
				OP_CLEAR: clear_legs();
				OP_LOAD:  spin_state[site_i] = spin_i;
				OP_READ: begin
					r.kind          = KIND_READOUT;
					r.leg0_valid    = first_ok[site_i];
					r.leg0_partner  = first_ok[site_i] ? first_leg[site_i][PART_W-1:0] : '0;
					r.leg1_valid    = last_ok[site_i];
					r.leg1_partner  = last_ok[site_i] ? last_leg[site_i][PART_W-1:0] : '0;
					r.final_spin_up = spin_state[site_i];
					pending_results.push_back(r);
				end
				default: begin
					// identity code: nothing happens
					if (code_i != '0) begin
						offdiag = code_i[0];
						if (vertex_count >= MAX_VERTICES ||
								!bond_ends(code_i >> 1, ends[0], ends[1])) begin
							r.kind         = KIND_ERROR;
							r.vertex_index = vertex_count[INDEX_W-1:0];
						end else begin
							r.kind         = KIND_VERTEX;
							r.vertex_index = vertex_count[INDEX_W-1:0];
							// lower legs link to the last leg on their site, in order
							for (int a = 0; a < 2; a++) begin
								st  = ends[a];
								leg = 4 * vertex_count + a;
								if (last_ok[st]) begin
									if (a == 0) begin
										r.leg0_valid   = 1'b1;
										r.leg0_partner = last_leg[st][PART_W-1:0];
									end else begin
										r.leg1_valid   = 1'b1;
										r.leg1_partner = last_leg[st][PART_W-1:0];
									end
								end else begin
									first_ok[st]  = 1'b1;
									first_leg[st] = leg;
								end
								last_ok[st]  = 1'b1;
								last_leg[st] = 4 * vertex_count + ((a == 0) ? 3 : 2);
							end
							r.vertex_type = vertex_class(offdiag, spin_state[ends[0]],
								spin_state[ends[1]]);
							if (offdiag) begin
								spin_state[ends[0]] ^= 1'b1;
								spin_state[ends[1]] ^= 1'b1;
							end
							vertex_count++;
						end
						pending_results.push_back(r);
					end
				end
			endcase
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_MISMATCHES)
					$display("%0t: result with nothing pending: kind %0d index %0d",
						$time, got.kind, got.vertex_index);
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind || got.vertex_index !== want.vertex_index ||
					got.vertex_type !== want.vertex_type ||
					got.leg0_valid !== want.leg0_valid ||
					got.leg0_partner !== want.leg0_partner ||
					got.leg1_valid !== want.leg1_valid ||
					got.leg1_partner !== want.leg1_partner ||
					got.final_spin_up !== want.final_spin_up) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_MISMATCHES) begin
					$display("%0t: expected kind %0d idx %0d type %0d leg0 %b/%0d leg1 %b/%0d spin %b",
						$time, want.kind, want.vertex_index, want.vertex_type, want.leg0_valid,
						want.leg0_partner, want.leg1_valid, want.leg1_partner,
						want.final_spin_up);
					$display("%0t: actual   kind %0d idx %0d type %0d leg0 %b/%0d leg1 %b/%0d spin %b",
						$time, got.kind, got.vertex_index, got.vertex_type, got.leg0_valid,
						got.leg0_partner, got.leg1_valid, got.leg1_partner,
						got.final_spin_up);
				end
			end
		endfunction
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  push          = 1'b0;
	logic                  full;
	logic [1:0]            op            = OP_CLEAR;
	logic [IN_SITE_W-1:0]  site          = '0;
	logic                  spin_up       = 1'b0;
	logic [CODE_W-1:0]     operator_code = '0;
	logic                  empty;
	logic                  pop           = 1'b0;
	logic [1:0]            kind;
	logic [INDEX_W-1:0]    vertex_index;
	logic [TYPE_W-1:0]     vertex_type;
	logic                  leg0_valid;
	logic [PART_W-1:0]     leg0_partner;
	logic                  leg1_valid;
	logic [PART_W-1:0]     leg1_partner;
	logic                  final_spin_up;
	logic                  wr_en         = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index      = CFG_LATTICE_WIDTH;
	logic [CFG_DATA_W-1:0] wr_data       = '0;

	bit             tx_idle_on = 1'b1;
	bit             rx_idle_on = 1'b1;
	int unsigned    rx_stall   = 0;
	link_scoreboard sb;

	always #10 clk = ~clk;

	vertex_link_builder_unit #(
		.MAX_SITES(MAX_SITES),
		.MAX_VERTICES(MAX_VERTICES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.site(site),
		.spin_up(spin_up),
		.operator_code(operator_code),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.vertex_index(vertex_index),
		.vertex_type(vertex_type),
		.leg0_valid(leg0_valid),
		.leg0_partner(leg0_partner),
		.leg1_valid(leg1_valid),
		.leg1_partner(leg1_partner),
		.final_spin_up(final_spin_up),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	function automatic logic [CODE_W-1:0] bond_code(int unsigned bond, bit offdiag);
		return 2 * bond + offdiag;
	endfunction

	// site inside the current lattice where there is one
	function automatic logic [IN_SITE_W-1:0] pick_site();
		int unsigned n;
		n = sb.lat_w * sb.lat_h;
		if (n >= 1 && n <= MAX_SITES) return $urandom_range(0, n - 1);
		return $urandom_range(0, 255);
	endfunction

	// operator code on a valid bond where the lattice has any
	function automatic logic [CODE_W-1:0] pick_code();
		int unsigned n, bonds;
		n = sb.lat_w * sb.lat_h;
		if (n < 1 || n > MAX_SITES) return $urandom_range(1, 2047);
		bonds = (sb.lat_h == 1) ? n : 2 * n;
		return bond_code($urandom_range(1, bonds), $urandom_range(0, 1));
	endfunction

	// one request; push stays high unless an idle burst follows
	task automatic send_request(input logic [1:0] op_v, input logic [IN_SITE_W-1:0] site_v,
			input logic spin_v, input logic [CODE_W-1:0] code_v);
		push          <= 1'b1;
		op            <= op_v;
		site          <= site_v;
		spin_up       <= spin_v;
		operator_code <= code_v;
		do @(posedge clk); while (full !== 1'b0);
		sb.note_request(op_v, site_v, spin_v, code_v);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// hold off until every result is back and a clear sweep could have ended
	task automatic drain_block();
		push <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_lattice(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		drain_block();
		wr_en    <= 1'b1;
		wr_index <= CFG_LATTICE_WIDTH;
		wr_data  <= w;
		@(posedge clk);
		sb.write_register(CFG_LATTICE_WIDTH, w);
		wr_index <= CFG_LATTICE_HEIGHT;
		wr_data  <= h;
		@(posedge clk);
		sb.write_register(CFG_LATTICE_HEIGHT, h);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// clear (mostly), a few loads, a run of operators, then some reads
	task automatic link_sequence(output int unsigned sent);
		int unsigned loads, ops, reads;
		loads = $urandom_range(1, 8);
		ops   = $urandom_range(4, 30);
		reads = $urandom_range(1, 4);
		sent  = loads + ops + reads;
		if ($urandom_range(0, 9) < 7) begin
			send_request(OP_CLEAR, $urandom, $urandom, $urandom);
			sent++;
		end
		repeat (loads) send_request(OP_LOAD, pick_site(), $urandom, $urandom);
		repeat (ops)
			send_request(OP_CODE, $urandom, $urandom,
				($urandom_range(0, 11) == 0) ? '0 : pick_code());
		repeat (reads) send_request(OP_READ, pick_site(), $urandom, $urandom);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input int unsigned count, input bit tx_on, input bit rx_on);
		int unsigned done_items, got;
		set_lattice(w, h);
		tx_idle_on = tx_on;
		rx_idle_on = rx_on;
		done_items = 0;
		while (done_items < count) begin
			if ($urandom_range(0, 4) != 0) begin
				link_sequence(got);
			end else begin
				// raw noise over every field
				got = $urandom_range(1, 6);
				repeat (got) send_request($urandom, $urandom, $urandom, $urandom);
			end
			done_items += got;
		end
	endtask

	task automatic directed_checks();
		// default 16 x 16 lattice, untouched stores
		send_request(OP_READ, 8'd255, 1'b1, 11'h7FF);
		send_request(OP_CLEAR, 8'd0, 1'b0, '0);
		send_request(OP_LOAD, 8'd0, 1'b1, '0);
		send_request(OP_LOAD, 8'd1, 1'b0, '0);
		send_request(OP_LOAD, 8'd16, 1'b1, '0);
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(1, 1'b0));    // +x bond, (+,-)
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(2, 1'b1));    // +y flip on (+,+)
		send_request(OP_CODE, 8'd0, 1'b0, '0);                    // identity
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(512, 1'b1));  // top bond wraps in y
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(513, 1'b0));  // past the last bond
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(0, 1'b1));    // bond zero
		send_request(OP_CODE, 8'd0, 1'b0, 11'h7FF);
		send_request(OP_READ, 8'd0, 1'b0, '0);
		send_request(OP_READ, 8'd16, 1'b0, '0);
		send_request(OP_READ, 8'd255, 1'b0, '0);
		// single site: both ends of a bond land on it
		set_lattice(9'd1, 9'd1);
		send_request(OP_CLEAR, 8'd0, 1'b0, '0);
		send_request(OP_LOAD, 8'd0, 1'b1, '0);
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(1, 1'b0));
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(1, 1'b1));
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(2, 1'b0));
		send_request(OP_READ, 8'd0, 1'b0, '0);
		// empty and oversized lattices reject every bond
		set_lattice(9'd0, 9'd37);
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(1, 1'b0));
		set_lattice(9'd256, 9'd256);
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(1, 1'b1));
		// longest chain, last bond wraps to site 0
		set_lattice(9'd256, 9'd1);
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(256, 1'b1));
		send_request(OP_READ, 8'd255, 1'b1, '0);
	endtask

	// fill the vertex counter, then check that it refuses further operators
	task automatic overflow_phase();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		set_lattice(9'd16, 9'd1);
		send_request(OP_CLEAR, 8'd0, 1'b0, '0);
		for (int i = 0; i < 16; i++) send_request(OP_LOAD, i, $urandom, '0);
		repeat (MAX_VERTICES) send_request(OP_CODE, $urandom, $urandom, pick_code());
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(1, 1'b0));
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(16, 1'b1));
		send_request(OP_CODE, 8'd0, 1'b0, '0);
		send_request(OP_READ, 8'd0, 1'b0, '0);
		send_request(OP_READ, 8'd15, 1'b0, '0);
		send_request(OP_READ, 8'd200, 1'b0, '0);
		send_request(OP_CLEAR, 8'd0, 1'b0, '0);
		send_request(OP_CODE, 8'd0, 1'b0, bond_code(16, 1'b1));
		send_request(OP_READ, 8'd0, 1'b0, '0);
	endtask

	// result side: check on every pop, random stall bursts when rx_idle_on is set
	initial begin : result_sink
		res_t seen;
		forever begin
			@(posedge clk);
			if (pop && empty === 1'b0) begin
				seen.kind          = kind;
				seen.vertex_index  = vertex_index;
				seen.vertex_type   = vertex_type;
				seen.leg0_valid    = leg0_valid;
				seen.leg0_partner  = leg0_partner;
				seen.leg1_valid    = leg1_valid;
				seen.leg1_partner  = leg1_partner;
				seen.final_spin_up = final_spin_up;
				sb.check_result(seen);
			end
			if (!rx_idle_on) begin
				pop <= 1'b1;
			end else if (rx_stall > 0) begin
				pop <= 1'b0;
				rx_stall--;
			end else if ($urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				rx_stall = $urandom_range(1, 14) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// request side
	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		directed_checks();
		run_phase(9'd16, 9'd16, 170, 1'b1, 1'b1);
		run_phase(9'd12, 9'd1, 170, 1'b0, 1'b0);
		run_phase(9'd1, 9'd256, 170, 1'b1, 1'b1);
		run_phase(9'd2, 9'd128, 170, 1'b1, 1'b0);
		run_phase(9'd256, 9'd1, 170, 1'b0, 1'b1);
		run_phase(9'd1, 9'd1, 120, 1'b1, 1'b1);
		run_phase(9'd3, 9'd85, 170, 1'b1, 1'b1);
		run_phase($urandom_range(1, 16), $urandom_range(1, 16), 170, 1'b1, 1'b1);
		run_phase($urandom_range(0, 511), $urandom_range(0, 511), 40, 1'b1, 1'b1);
		overflow_phase();
		push <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// hang guard
	initial begin
		#(RUN_LIMIT_NS);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
